// ===== hw/rtl/tsli_pkg.sv =====
// tsli_pkg: shared types for the timestamp lru slot insert block
// transaction payload structs, scan flag struct and control state codes
// no dependencies
package tsli_pkg;

	// input transaction payload
	typedef struct packed {
		logic [31:0] now_time;
		logic [15:0] object_handle;
		logic [15:0] info_handle;
	} tsli_in_t;

	// result transaction payload
	typedef struct packed {
		logic [3:0]  slot_index;
		logic        evicted;
		logic [15:0] evicted_object;
		logic [15:0] evicted_info;
		logic [4:0]  occupancy;
	} tsli_out_t;

	// search flags handed from cell to cell
	typedef struct packed {
		logic have_empty;
		logic have_valid;
	} scan_flags_t;

	// sequencer states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_WRITE
	} tsli_state_t;

	// register reset value: all slots active
	localparam logic [4:0] ACTIVE_SLOTS_RESET = 5'd16;

endpackage

// ===== hw/rtl/tsli_cell.sv =====
// tsli_cell: one slot of the table plus one stage of the search chain
// merges its slot into the running empty/oldest search and registers it
// depends on tsli_pkg
module tsli_cell #(
	parameter int SLOTS      = 16,
	parameter int STAMP_BITS = 32,
	parameter int IDX        = 0
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic [$clog2(SLOTS+1)-1:0]  act,
	// search record from the previous cell
	input  tsli_pkg::scan_flags_t       flags_in,
	input  logic [$clog2(SLOTS)-1:0]    empty_idx_in,
	input  logic [$clog2(SLOTS)-1:0]    old_idx_in,
	input  logic [STAMP_BITS-1:0]       old_stamp_in,
	input  logic [15:0]                 old_obj_in,
	input  logic [15:0]                 old_info_in,
	// search record to the next cell
	output tsli_pkg::scan_flags_t       flags_out,
	output logic [$clog2(SLOTS)-1:0]    empty_idx_out,
	output logic [$clog2(SLOTS)-1:0]    old_idx_out,
	output logic [STAMP_BITS-1:0]       old_stamp_out,
	output logic [15:0]                 old_obj_out,
	output logic [15:0]                 old_info_out,
	// write-back broadcast
	input  logic                        wr_en,
	input  logic [$clog2(SLOTS)-1:0]    wr_idx,
	input  logic [STAMP_BITS-1:0]       wr_stamp,
	input  logic [15:0]                 wr_obj,
	input  logic [15:0]                 wr_info
);
	import tsli_pkg::*;

	localparam int CW = $clog2(SLOTS+1);
	localparam int IW = $clog2(SLOTS);

	logic                  valid_q;
	logic [STAMP_BITS-1:0] stamp_q;
	logic [15:0]           obj_q;
	logic [15:0]           info_q;

	scan_flags_t           flags_d;
	logic [IW-1:0]         empty_idx_d;
	logic [IW-1:0]         old_idx_d;
	logic [STAMP_BITS-1:0] old_stamp_d;
	logic [15:0]           old_obj_d;
	logic [15:0]           old_info_d;
	logic                  active;

	assign active = CW'(IDX) < act;

	always_comb begin
		flags_d     = flags_in;
		empty_idx_d = empty_idx_in;
		old_idx_d   = old_idx_in;
		old_stamp_d = old_stamp_in;
		old_obj_d   = old_obj_in;
		old_info_d  = old_info_in;
		if (active) begin
			if (!valid_q) begin
				if (!flags_in.have_empty) begin
					flags_d.have_empty = 1'b1;
					empty_idx_d        = IW'(IDX);
				end
			end else if (!flags_in.have_valid || stamp_q < old_stamp_in) begin
				// strictly smaller keeps the lowest index on ties
				flags_d.have_valid = 1'b1;
				old_idx_d          = IW'(IDX);
				old_stamp_d        = stamp_q;
				old_obj_d          = obj_q;
				old_info_d         = info_q;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flags_out <= '0;
			valid_q   <= 1'b0;
		end else begin
			flags_out <= flags_d;
			if (wr_en && wr_idx == IW'(IDX)) begin
				valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		empty_idx_out <= empty_idx_d;
		old_idx_out   <= old_idx_d;
		old_stamp_out <= old_stamp_d;
		old_obj_out   <= old_obj_d;
		old_info_out  <= old_info_d;
		if (wr_en && wr_idx == IW'(IDX)) begin
			stamp_q <= wr_stamp;
			obj_q   <= wr_obj;
			info_q  <= wr_info;
		end
	end

endmodule

// ===== hw/rtl/timestamp_lru_slot_insert_top.sv =====
// timestamp_lru_slot_insert_top: fully associative slot table with oldest-stamp eviction
// a row of tsli_cell slots searched as a chain, plus the sequencer and output register
// depends on tsli_pkg and tsli_cell
//
// channel | direction | handshake            | payload
// --------+-----------+----------------------+---------------------------
// in      | input     | in_valid / in_ready  | in_data  (tsli_in_t)
// out     | output    | out_valid / out_ready| out_data (tsli_out_t)
// cfg     | input     | cfg_valid / cfg_ready| cfg_data (active_slots)
//
// one transaction passes through accept, a scan while the search record ripples one cell
// per cycle down the chain, then the write-back into the chosen slot.
// in_ready is high only while idle; a finished result waits in the output register
// and the next transaction is taken meanwhile. a full output register holds the
// write-back until it drains. reset empties every slot and restores active_slots
// to 16; slot contents are not cleared. cfg_ready is always high.
module timestamp_lru_slot_insert_top #(
	parameter int SLOTS      = 16,
	parameter int STAMP_BITS = 32
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  tsli_pkg::tsli_in_t  in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output tsli_pkg::tsli_out_t out_data,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [4:0]          cfg_data
);
	import tsli_pkg::*;

	localparam int CW = $clog2(SLOTS+1);
	localparam int IW = $clog2(SLOTS);

	// configuration register and its clamped value
	logic [4:0]    active_slots_q;
	logic [CW-1:0] act;

	// sequencer
	tsli_state_t   state_q;
	tsli_state_t   state_d;
	logic [IW-1:0] cnt_q;
	logic          accept;
	logic          wr_fire;

	// latched input transaction
	logic [STAMP_BITS-1:0] stamp_q;
	logic [15:0]           obj_q;
	logic [15:0]           info_q;

	logic [CW-1:0] used_q;
	logic [CW-1:0] used_next;

	// search chain, entry 0 is the empty seed
	scan_flags_t           ch_flags [SLOTS+1];
	logic [IW-1:0]         ch_empty [SLOTS+1];
	logic [IW-1:0]         ch_old   [SLOTS+1];
	logic [STAMP_BITS-1:0] ch_stamp [SLOTS+1];
	logic [15:0]           ch_obj   [SLOTS+1];
	logic [15:0]           ch_info  [SLOTS+1];

	// write-back decision from the chain tail
	logic          use_empty;
	logic [IW-1:0] wr_idx;

	logic      out_valid_q;
	tsli_out_t out_data_q;

	assign cfg_ready = 1'b1;

	// zero acts as one, anything past the table size as the table size
	always_comb begin
		if (active_slots_q == '0) begin
			act = CW'(1);
		end else if (32'(active_slots_q) > SLOTS) begin
			act = CW'(SLOTS);
		end else begin
			act = CW'(active_slots_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_slots_q <= ACTIVE_SLOTS_RESET;
		end else if (cfg_valid && cfg_ready) begin
			active_slots_q <= cfg_data;
		end
	end

	assign in_ready = (state_q == ST_IDLE);
	assign accept   = in_valid && in_ready;
	assign wr_fire  = (state_q == ST_WRITE) && (!out_valid_q || out_ready);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) state_d = ST_SCAN;
			end
			ST_SCAN: begin
				// leave the scan once the tail record has settled
				if (cnt_q == IW'(SLOTS-1)) state_d = ST_WRITE;
			end
			ST_WRITE: begin
				if (wr_fire) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_SCAN) begin
				cnt_q <= cnt_q + IW'(1);
			end else begin
				cnt_q <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			stamp_q <= STAMP_BITS'(in_data.now_time);
			obj_q   <= in_data.object_handle;
			info_q  <= in_data.info_handle;
		end
	end

	// chain seed: nothing found yet
	assign ch_flags[0] = '0;
	assign ch_empty[0] = '0;
	assign ch_old[0]   = '0;
	assign ch_stamp[0] = '0;
	assign ch_obj[0]   = '0;
	assign ch_info[0]  = '0;

	for (genvar g = 0; g < SLOTS; g++) begin : g_cell
		tsli_cell #(
			.SLOTS      (SLOTS),
			.STAMP_BITS (STAMP_BITS),
			.IDX        (g)
		) u_cell (
			.clk           (clk),
			.arst_n        (arst_n),
			.act           (act),
			.flags_in      (ch_flags[g]),
			.empty_idx_in  (ch_empty[g]),
			.old_idx_in    (ch_old[g]),
			.old_stamp_in  (ch_stamp[g]),
			.old_obj_in    (ch_obj[g]),
			.old_info_in   (ch_info[g]),
			.flags_out     (ch_flags[g+1]),
			.empty_idx_out (ch_empty[g+1]),
			.old_idx_out   (ch_old[g+1]),
			.old_stamp_out (ch_stamp[g+1]),
			.old_obj_out   (ch_obj[g+1]),
			.old_info_out  (ch_info[g+1]),
			.wr_en         (wr_fire),
			.wr_idx        (wr_idx),
			.wr_stamp      (stamp_q),
			.wr_obj        (obj_q),
			.wr_info       (info_q)
		);
	end

	// fill an empty active slot while the count has room, or when no active slot is valid
	assign use_empty = ch_flags[SLOTS].have_empty
		&& (used_q < act || !ch_flags[SLOTS].have_valid);
	assign wr_idx    = use_empty ? ch_empty[SLOTS] : ch_old[SLOTS];
	assign used_next = (use_empty && used_q < CW'(SLOTS)) ? used_q + CW'(1) : used_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (wr_fire) begin
				used_q      <= used_next;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr_fire) begin
			out_data_q.slot_index     <= 4'(wr_idx);
			out_data_q.evicted        <= !use_empty;
			out_data_q.evicted_object <= use_empty ? 16'd0 : ch_obj[SLOTS];
			out_data_q.evicted_info   <= use_empty ? 16'd0 : ch_info[SLOTS];
			out_data_q.occupancy      <= 5'(used_next);
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule

// ===== hw/rtl/tsli_checker.sv =====
// tsli_checker: port-level checks for timestamp_lru_slot_insert_top
// bound to the top level below; depends on tsli_pkg
module tsli_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                in_valid,
	input logic                in_ready,
	input logic                out_valid,
	input logic                out_ready,
	input tsli_pkg::tsli_out_t out_data
);
	import tsli_pkg::*;

	// one transaction at a time: ready drops right after an accept
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("in_ready still high after accept");

	// a result that is stalled holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(out_data)))
		else $error("stalled result changed");

	// no eviction reports zero handles
	a_no_evict_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_data.evicted) |->
		(out_data.evicted_object == 16'd0 && out_data.evicted_info == 16'd0))
		else $error("handles reported without eviction");

	// after any insert the table holds at least one entry
	a_occ_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_data.occupancy != 5'd0))
		else $error("zero occupancy after insert");

endmodule

bind timestamp_lru_slot_insert_top tsli_checker u_tsli_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_data  (out_data)
);

// ===== dv/tb_timestamp_lru_slot_insert_top.sv =====
// tb_timestamp_lru_slot_insert_top: self-checking testbench for the lru slot insert block
// drives insert and active_slots transactions, predicts every placement and checks each result
// depends on tsli_pkg and timestamp_lru_slot_insert_top
module tb_timestamp_lru_slot_insert_top;
	timeunit 1ns;
	timeprecision 1ps;

	import tsli_pkg::*;

	localparam int SLOTS        = 16;
	localparam int STAMP_BITS   = 32;
	// cycles with no transaction on any channel before the run counts as hung;
	// slowest legit quiet stretch is the receiver hold plus one insert
	localparam int IDLE_LIMIT   = 3000;
	// settling wait after the last predicted result has come back
	localparam int DRAIN_CYCLES = 40;
	localparam int HOLD_CYCLES  = 400;

	logic      clk;
	logic      arst_n;
	logic      in_valid;
	logic      in_ready;
	tsli_in_t  in_data;
	logic      out_valid;
	logic      out_ready;
	tsli_out_t out_data;
	logic      cfg_valid;
	logic      cfg_ready;
	logic [4:0] cfg_data;

	timestamp_lru_slot_insert_top #(
		.SLOTS      (SLOTS),
		.STAMP_BITS (STAMP_BITS)
	) u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	// shadow copy of the slot table, updated at each accepted insert
	logic [STAMP_BITS-1:0] tbl_stamp  [SLOTS];
	logic [15:0]           tbl_object [SLOTS];
	logic [15:0]           tbl_info   [SLOTS];
	bit                    tbl_valid  [SLOTS];
	int unsigned           tbl_used;
	logic [4:0]            tbl_active;

	// placements predicted for accepted inserts, oldest first
	tsli_out_t placement_q [$];

	int          errors;
	int          inserts_sent;
	int          results_seen;
	int          evictions_seen;
	int          cfg_writes;
	int          send_idle_pct;
	int          recv_idle_pct;
	int          recv_hold;
	int          quiet_cycles;
	int unsigned wall_clock;

	// 12 ns period
	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	// placement rule: lowest empty active slot while there is room or no active slot is valid,
	// else the oldest valid active slot, ties to the lowest index
	function automatic tsli_out_t place_entry(tsli_in_t item);
		tsli_out_t res;
		int        span;
		bit        have_empty;
		bit        have_valid;
		bit        evict;
		int        empty_idx;
		int        old_idx;
		int        slot;
		// register value 0 behaves as 1, anything above the table size as the table size
		if (tbl_active == 5'd0)
			span = 1;
		else if (int'(tbl_active) > SLOTS)
			span = SLOTS;
		else
			span = int'(tbl_active);
		have_empty = 1'b0;
		have_valid = 1'b0;
		empty_idx  = 0;
		old_idx    = 0;
		for (int i = 0; i < span; i++) begin
			if (!tbl_valid[i]) begin
				if (!have_empty) begin
					have_empty = 1'b1;
					empty_idx  = i;
				end
			end else if (!have_valid || tbl_stamp[i] < tbl_stamp[old_idx]) begin
				have_valid = 1'b1;
				old_idx    = i;
			end
		end
		res = '0;
		// a shrunken table can leave used count at or above the active count
		if (have_empty && (tbl_used < span || !have_valid)) begin
			evict = 1'b0;
			slot  = empty_idx;
		end else begin
			evict              = 1'b1;
			slot               = old_idx;
			res.evicted_object = tbl_object[slot];
			res.evicted_info   = tbl_info[slot];
		end
		tbl_stamp[slot]  = item.now_time[STAMP_BITS-1:0];
		tbl_object[slot] = item.object_handle;
		tbl_info[slot]   = item.info_handle;
		tbl_valid[slot]  = 1'b1;
		if (!evict && tbl_used < SLOTS)
			tbl_used++;
		res.slot_index = 4'(slot);
		res.evicted    = evict;
		res.occupancy  = 5'(tbl_used);
		return res;
	endfunction

	function automatic void flag_mismatch(string field, logic [31:0] want_v, logic [31:0] got_v);
		errors++;
		$display("%0t: %s mismatch, expected %0h actual %0h", $time, field, want_v, got_v);
	endfunction

	function automatic void check_placement(tsli_out_t got);
		tsli_out_t want;
		results_seen++;
		if (placement_q.size() == 0) begin
			errors++;
			$display("%0t: result with no insert pending, actual %h", $time, got);
			return;
		end
		want = placement_q.pop_front();
		if (got.slot_index !== want.slot_index)
			flag_mismatch("slot_index", 32'(want.slot_index), 32'(got.slot_index));
		if (got.evicted !== want.evicted)
			flag_mismatch("evicted", 32'(want.evicted), 32'(got.evicted));
		if (got.evicted_object !== want.evicted_object)
			flag_mismatch("evicted_object", 32'(want.evicted_object),
				32'(got.evicted_object));
		if (got.evicted_info !== want.evicted_info)
			flag_mismatch("evicted_info", 32'(want.evicted_info), 32'(got.evicted_info));
		if (got.occupancy !== want.occupancy)
			flag_mismatch("occupancy", 32'(want.occupancy), 32'(got.occupancy));
		if (got.evicted === 1'b1)
			evictions_seen++;
	endfunction

	// stamps: mostly a running clock (with repeats, so ties happen), some from a
	// tiny range, some fully random, some at the extremes
	function automatic logic [31:0] pick_stamp();
		int unsigned mode;
		mode = $urandom_range(99);
		if (mode < 50) begin
			wall_clock += $urandom_range(0, 3);
			return wall_clock;
		end
		if (mode < 70)
			return 32'($urandom_range(0, 7));
		if (mode < 85)
			return $urandom;
		return ($urandom_range(1) == 0) ? 32'h0000_0000 : 32'hFFFF_FFFF;
	endfunction

	function automatic tsli_in_t random_insert();
		tsli_in_t item;
		item.now_time      = pick_stamp();
		item.object_handle = 16'($urandom);
		item.info_handle   = 16'($urandom);
		return item;
	endfunction

	// small tables often so evictions are common, plus the full size, the out-of-range codes and random values
	function automatic logic [4:0] pick_active();
		case ($urandom_range(9))
			0: return 5'd0;
			1: return 5'd1;
			2: return 5'd2;
			3: return 5'd3;
			4: return 5'd16;
			5: return 5'd17;
			6: return 5'd31;
			default: return 5'($urandom_range(31));
		endcase
	endfunction

	// one insert transaction; valid stays up across back-to-back items
	task automatic send_insert(input tsli_in_t item);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= item;
		do @(posedge clk); while (!in_ready);
		placement_q.push_back(place_entry(item));
		inserts_sent++;
	endtask

	// stop offering inserts, wait for every predicted result, then let the block settle
	task automatic settle_table();
		in_valid <= 1'b0;
		while (placement_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// register writes only with the block idle
	task automatic write_active_slots(input logic [4:0] value);
		settle_table();
		cfg_valid <= 1'b1;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid  <= 1'b0;
		tbl_active  = value;
		cfg_writes++;
	endtask

	// corner cases in a fixed order, no idling on either side
	task automatic test_directed();
		send_idle_pct = 0;
		recv_idle_pct = 0;
		// reset width of 16: extremes of every field
		send_insert(tsli_in_t'{32'hFFFF_FFFF, 16'hFFFF, 16'h0000});
		send_insert(tsli_in_t'{32'h0000_0000, 16'h0000, 16'hFFFF});
		send_insert(tsli_in_t'{32'h0000_0005, 16'h1234, 16'h5678});
		// full at three: oldest goes first, then a stamp tie resolves to the lower slot
		write_active_slots(5'd3);
		send_insert(tsli_in_t'{32'h0000_0005, 16'hAAAA, 16'h5555});
		send_insert(tsli_in_t'{32'h0000_0007, 16'h0F0F, 16'hF0F0});
		// zero acts as one slot
		write_active_slots(5'd0);
		send_insert(tsli_in_t'{32'h0000_0001, 16'h8001, 16'h7FFE});
		send_insert(tsli_in_t'{32'h0000_0000, 16'h4000, 16'h0002});
		// above the table size acts as the full table, empty slots fill again
		write_active_slots(5'd31);
		send_insert(tsli_in_t'{32'h8000_0000, 16'h00FF, 16'hFF00});
		send_insert(tsli_in_t'{32'h7FFF_FFFF, 16'hFF00, 16'h00FF});
		// shrunk below occupancy: only the low slots are searched
		write_active_slots(5'd2);
		send_insert(tsli_in_t'{32'hFFFF_FFFE, 16'hC3C3, 16'h3C3C});
		send_insert(tsli_in_t'{32'h0000_0002, 16'h3C3C, 16'hC3C3});
		write_active_slots(5'd1);
		send_insert(tsli_in_t'{32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF});
		write_active_slots(5'd16);
		send_insert(tsli_in_t'{32'h0000_0000, 16'h0000, 16'h0000});
	endtask

	// random inserts under one idle mix, with a fresh table size every hundred
	task automatic test_random_phase(input int sender_pct, input int receiver_pct,
			input int count);
		send_idle_pct = sender_pct;
		recv_idle_pct = receiver_pct;
		for (int k = 0; k < count; k++) begin
			if (k % 100 == 0)
				write_active_slots(pick_active());
			send_insert(random_insert());
		end
	endtask

	// receiver stalls for a long stretch while inserts keep coming, so the
	// output register fills and in_ready stays low
	task automatic test_receiver_hold();
		write_active_slots(5'd3);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		recv_hold     = HOLD_CYCLES;
		repeat (24) send_insert(random_insert());
	endtask

	// sender goes quiet until every result is back, then resumes
	task automatic test_sender_pause();
		send_idle_pct = 10;
		recv_idle_pct = 10;
		repeat (15) send_insert(random_insert());
		settle_table();
		repeat (15) send_insert(random_insert());
	endtask

	// receiver side: checks each result transaction and paces out_ready
	initial begin
		out_ready = 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && out_valid && out_ready)
				check_placement(out_data);
			// the long hold is counted here, one cycle per edge
			if (recv_hold > 0) begin
				recv_hold--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	// watchdog on cycles with no transaction on any channel
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)
				|| (cfg_valid && cfg_ready)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
			if (quiet_cycles >= IDLE_LIMIT) begin
				$display("%0t: timeout, no transaction for %0d cycles", $time, IDLE_LIMIT);
				$display("CHECKS FAILED");
				$finish;
			end
		end
	end

	initial begin
		arst_n         = 1'b0;
		in_valid       = 1'b0;
		in_data        = '0;
		cfg_valid      = 1'b0;
		cfg_data       = '0;
		errors         = 0;
		inserts_sent   = 0;
		results_seen   = 0;
		evictions_seen = 0;
		cfg_writes     = 0;
		send_idle_pct  = 0;
		recv_idle_pct  = 0;
		recv_hold      = 0;
		quiet_cycles   = 0;
		wall_clock     = $urandom;
		// table after reset: every slot empty, full width active
		for (int i = 0; i < SLOTS; i++) begin
			tbl_stamp[i]  = '0;
			tbl_object[i] = '0;
			tbl_info[i]   = '0;
			tbl_valid[i]  = 1'b0;
		end
		tbl_used   = 0;
		tbl_active = ACTIVE_SLOTS_RESET;

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		test_directed();
		test_random_phase(23, 75, 400);
		test_receiver_hold();
		test_random_phase(75, 23, 400);
		test_sender_pause();
		test_random_phase(0, 0, 400);
		settle_table();

		if (placement_q.size() != 0) begin
			errors++;
			$display("%0t: %0d results never arrived", $time, placement_q.size());
		end
		$display("run: %0d inserts, %0d results, %0d evictions, %0d active_slots writes",
			inserts_sent, results_seen, evictions_seen, cfg_writes);
		$display("run: corner stamps and table sizes, three idle mixes, a long output stall");
		if (errors == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
